// ----- design/b64cc_pkg.sv -----
// Shared types, constants and symbol mapping functions for the base64 codec.
// No dependencies; used by every module of the codec.
package b64cc_pkg;

  localparam int unsigned GQ_DEPTH = 2;

  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] ChLowG    = 8'h67;  // 'g'
  localparam logic [7:0] ChLowZ    = 8'h7A;  // 'z'
  localparam logic [7:0] ChLowA    = 8'h61;  // 'a'
  localparam logic [7:0] ChLowF    = 8'h66;  // 'f'
  localparam logic [7:0] ChUpA     = 8'h41;  // 'A'
  localparam logic [7:0] ChUpZ     = 8'h5A;  // 'Z'
  localparam logic [7:0] ChZero    = 8'h30;  // '0'
  localparam logic [7:0] ChNine    = 8'h39;  // '9'
  localparam logic [7:0] ChPlus    = 8'h2B;  // '+'
  localparam logic [7:0] ChSlash   = 8'h2F;  // '/'

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // One completed group handed from front to back.
  typedef struct packed {
    logic [23:0] bits;
    logic        dir;    // DirEncode / DirDecode
    logic [1:0]  held;   // encode: bytes in group, 1..3
    logic        last;
  } grp_t;

  function automatic logic [7:0] alphabet(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] ch;
    v8 = {2'b00, v};
    if (v8 inside {[8'd0:8'd19]}) begin
      ch = v8 + ChLowG;
    end else if (v8 inside {[8'd20:8'd29]}) begin
      ch = v8 - 8'd20 + ChZero;
    end else if (v8 == 8'd30) begin
      ch = ChPlus;
    end else if (v8 == 8'd31) begin
      ch = ChSlash;
    end else if (v8 inside {[8'd32:8'd57]}) begin
      ch = v8 - 8'd32 + ChUpA;
    end else begin
      ch = v8 - 8'd58 + ChLowA;
    end
    return ch;
  endfunction

  function automatic logic [5:0] symbol_value(input logic [7:0] ch);
    logic [7:0] v;
    if (ch inside {[ChLowG:ChLowZ]}) begin
      v = ch - ChLowG;
    end else if (ch inside {[ChZero:ChNine]}) begin
      v = ch - ChZero + 8'd20;
    end else if (ch == ChPlus) begin
      v = 8'd30;
    end else if (ch == ChSlash) begin
      v = 8'd31;
    end else if (ch inside {[ChUpA:ChUpZ]}) begin
      v = ch - ChUpA + 8'd32;
    end else if (ch inside {[ChLowA:ChLowF]}) begin
      v = ch - ChLowA + 8'd58;
    end else begin
      v = 8'd0;
    end
    return v[5:0];
  endfunction

endpackage

// ----- design/b64cc_front.sv -----
// Front end: direction register, input accept and group assembly.
// Pushes one b64cc_pkg::grp_t per completed group into the group queue.
module b64cc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_direction_i,
  input  logic              push_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_item_i,
  input  logic              gq_full_i,
  output logic              full_o,
  output logic              gq_push_o,
  output b64cc_pkg::grp_t   gq_wdata_o
);

  logic        dir_q;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  count_q, count_d;
  logic [1:0]  held;
  logic        accept;
  logic        complete;
  logic [5:0]  sym;

  assign full_o = gq_full_i;
  assign accept = push_i & ~gq_full_i;
  assign sym    = b64cc_pkg::symbol_value(data_byte_i);

  always_comb begin
    held     = count_q;
    bits_d   = bits_q;
    complete = 1'b0;
    if (dir_q == b64cc_pkg::DirEncode) begin
      if (held == 2'd3) held = 2'd2;
      case (held)
        2'd0:    bits_d = bits_q | {data_byte_i, 16'h0000};
        2'd1:    bits_d = bits_q | {8'h00, data_byte_i, 8'h00};
        default: bits_d = bits_q | {16'h0000, data_byte_i};
      endcase
      complete = (held == 2'd2) | last_item_i;
    end else begin
      case (held)
        2'd0:    bits_d = bits_q | {sym, 18'h00000};
        2'd1:    bits_d = bits_q | {6'h00, sym, 12'h000};
        2'd2:    bits_d = bits_q | {12'h000, sym, 6'h00};
        default: bits_d = bits_q | {18'h00000, sym};
      endcase
      complete = (held == 2'd3) | last_item_i;
    end
    count_d = complete ? 2'd0 : held + 2'd1;
  end

  assign gq_push_o       = accept & complete;
  assign gq_wdata_o.bits = bits_d;
  assign gq_wdata_o.dir  = dir_q;
  assign gq_wdata_o.held = held + 2'd1;
  assign gq_wdata_o.last = last_item_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= b64cc_pkg::DirEncode;
      bits_q  <= 24'h000000;
      count_q <= 2'd0;
    end else if (cfg_valid_i) begin
      // direction write drops any partial group
      dir_q   <= cfg_direction_i;
      bits_q  <= 24'h000000;
      count_q <= 2'd0;
    end else if (accept) begin
      bits_q  <= complete ? 24'h000000 : bits_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- design/b64cc_gfifo.sv -----
// Short queue of completed groups between front and back end.
// Depends on b64cc_pkg::grp_t.
module b64cc_gfifo #(
  parameter int unsigned Depth = b64cc_pkg::GQ_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64cc_pkg::grp_t   wdata_i,
  input  logic              pop_i,
  output b64cc_pkg::grp_t   rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64cc_pkg::grp_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] inc_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= inc_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= inc_ptr(rd_ptr_q);
      if (do_push & ~do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop & ~do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- design/b64cc_back.sv -----
// Back end: serializes the queue head into beats through a registered
// output slot, one per cycle unless stalled. Depends on b64cc_pkg.
module b64cc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64cc_pkg::grp_t   grp_i,
  input  logic              gq_empty_i,
  output logic              gq_pop_o,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_byte_o,
  output logic              last_out_o
);

  logic [1:0] beat_q;
  logic       ov_q;
  logic [7:0] ob_q;
  logic       ol_q;
  logic       take;
  logic       fin;
  logic [5:0] sextet;
  logic [7:0] beat_byte;

  assign take = ~gq_empty_i & (~ov_q | pop);

  always_comb begin
    sextet    = grp_i.bits[23:18];
    beat_byte = grp_i.bits[23:16];
    if (grp_i.dir == b64cc_pkg::DirEncode) begin
      fin = (beat_q == 2'd3);
      case (beat_q)
        2'd0:    sextet = grp_i.bits[23:18];
        2'd1:    sextet = grp_i.bits[17:12];
        2'd2:    sextet = grp_i.bits[11:6];
        default: sextet = grp_i.bits[5:0];
      endcase
      beat_byte = (beat_q > grp_i.held) ? b64cc_pkg::PadChar
                                        : b64cc_pkg::alphabet(sextet);
    end else begin
      fin = (beat_q == 2'd2);
      case (beat_q)
        2'd0:    beat_byte = grp_i.bits[23:16];
        2'd1:    beat_byte = grp_i.bits[15:8];
        default: beat_byte = grp_i.bits[7:0];
      endcase
    end
  end

  assign gq_pop_o   = take & fin;
  assign empty      = ~ov_q;
  assign out_byte_o = ob_q;
  assign last_out_o = ol_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      ob_q <= beat_byte;
      ol_q <= fin & grp_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= 2'd0;
      ov_q   <= 1'b0;
    end else begin
      if (take) beat_q <= fin ? 2'd0 : beat_q + 2'd1;
      if (take)     ov_q <= 1'b1;
      else if (pop) ov_q <= 1'b0;
    end
  end

endmodule

// ----- design/base64_codec_custom_alphabet_unit.sv -----
// Streaming base64 codec, permuted alphabet, encode or decode per direction.
// The item that completes a group enters the group queue, then its first
// result is registered into the output slot; results leave at one beat per
// cycle while popped. Throughput is set by the back end, 4 beats per 3 bytes
// encoding and 3 beats per 4 chars decoding; the group queue absorbs bursts.
// Reset (rst_ni low, async): direction encode, partial group and queues empty.
module base64_codec_custom_alphabet_unit #(
  parameter int unsigned GqDepth = b64cc_pkg::GQ_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_direction_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_item_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_out_o
);

  b64cc_pkg::grp_t gq_wdata, gq_rdata;
  logic            gq_push, gq_pop, gq_full, gq_empty;

  assign cfg_ready_o = 1'b1;

  b64cc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_direction_i (cfg_direction_i),
    .push_i          (push),
    .data_byte_i     (data_byte_i),
    .last_item_i     (last_item_i),
    .gq_full_i       (gq_full),
    .full_o          (full),
    .gq_push_o       (gq_push),
    .gq_wdata_o      (gq_wdata)
  );

  b64cc_gfifo #(
    .Depth (GqDepth)
  ) u_gfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (gq_push),
    .wdata_i (gq_wdata),
    .pop_i   (gq_pop),
    .rdata_o (gq_rdata),
    .full_o  (gq_full),
    .empty_o (gq_empty)
  );

  b64cc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_i      (gq_rdata),
    .gq_empty_i (gq_empty),
    .gq_pop_o   (gq_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte_o (out_byte_o),
    .last_out_o (last_out_o)
  );

endmodule
